### hdl/kcht_pkg.sv
// ----------------------------------------------------------------------------
// kcht_pkg
// Shared types and constants of the k-mer counting hash table.
// ----------------------------------------------------------------------------
package kcht_pkg;

  localparam int KC_BUCKETS_DEF    = 8192;
  localparam int KC_NODES_DEF      = 4096;
  localparam int KC_COUNT_BITS_DEF = 32;

  localparam int KC_NODE_ID_NULL = 0;

  localparam int KC_WORD_W   = 64;
  localparam int KC_IDX_W    = 12;
  localparam int KC_RCOUNT_W = 32;
  localparam int KC_TSIZE_W  = 14;
  localparam int KC_KWORDS_W = 2;
  localparam int KC_NLIMIT_W = 12;
  localparam int KC_CFG_W    = 14;
  localparam int KC_CFGIDX_W = 2;

  // Hash remainder is resolved this many bits per cycle
  localparam int KC_DIV_BITS  = 4;
  localparam int KC_DIV_STEPS = KC_WORD_W / KC_DIV_BITS;

  typedef enum logic [KC_CFGIDX_W-1:0] {
    REG_TABLE_SIZE = 2'd0,
    REG_KMER_WORDS = 2'd1,
    REG_NODE_LIMIT = 2'd2
  } kcht_reg_e;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } kcht_cmd_e;

  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_READ     = 3'd3,
    ST_RANGE    = 3'd4,
    ST_CLEARED  = 3'd5
  } kcht_status_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } kcht_fr_state_e;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_WALK,
    BK_CMP,
    BK_LINK,
    BK_RDOUT
  } kcht_bk_state_e;

endpackage

### hdl/kcht_fifo.sv
// ----------------------------------------------------------------------------
// kcht_fifo
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module kcht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/kcht_front.sv
// ----------------------------------------------------------------------------
// kcht_front
// Takes command beats, hashes add k-mers to a bucket, queues jobs.
// ----------------------------------------------------------------------------
module kcht_front import kcht_pkg::*; #(
  parameter int BUCKETS = KC_BUCKETS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [KC_TSIZE_W-1:0]  table_size_i,
  input  logic [KC_KWORDS_W-1:0] kmer_words_i,
  input  logic                   init_busy_i,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [1:0]             command_i,
  input  logic [KC_WORD_W-1:0]   kmer_low_i,
  input  logic [KC_WORD_W-1:0]   kmer_high_i,
  input  logic [KC_IDX_W-1:0]    entry_index_i,
  output logic                   job_push_o,
  output logic [2+1+2*KC_WORD_W+KC_IDX_W+$clog2(BUCKETS)-1:0] job_data_o,
  input  logic                   job_full_i
);

  localparam int BiW   = $clog2(BUCKETS);
  localparam int DvW   = $clog2(BUCKETS + 1);
  localparam int StepW = $clog2(KC_DIV_STEPS);

  kcht_fr_state_e state_q, state_d;

  logic [1:0]           cmd_q;
  logic                 two_q;
  logic [KC_WORD_W-1:0] lo_q, hi_q, sum_q, sum_n;
  logic [KC_IDX_W-1:0]  idx_q;
  logic [DvW-1:0]       rem_q, rem_n, divisor;
  logic [StepW-1:0]     step_q;
  logic                 accept, two_in;
  logic [KC_WORD_W-1:0] hi_in;

  // Buckets in use, clamped to 1..BUCKETS
  always_comb begin
    if (table_size_i == '0) begin
      divisor = DvW'(1);
    end else if (32'(table_size_i) > 32'(BUCKETS)) begin
      divisor = DvW'(BUCKETS);
    end else begin
      divisor = DvW'(table_size_i);
    end
  end

  assign two_in = kmer_words_i[1];
  assign hi_in  = two_in ? kmer_high_i : '0;
  assign accept = push_i && !full_o;

  // Restoring remainder, KC_DIV_BITS bits per cycle
  always_comb begin
    logic [DvW:0]         r2;
    logic [DvW-1:0]       r;
    logic [KC_WORD_W-1:0] s;
    r = rem_q;
    s = sum_q;
    for (int i = 0; i < KC_DIV_BITS; i++) begin
      r2 = {r, s[KC_WORD_W-1]};
      s  = {s[KC_WORD_W-2:0], 1'b0};
      if (r2 >= {1'b0, divisor}) begin
        r = DvW'(r2 - {1'b0, divisor});
      end else begin
        r = r2[DvW-1:0];
      end
    end
    rem_n = r;
    sum_n = s;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: begin
        if (accept) begin
          state_d = (command_i == CMD_ADD) ? FR_DIV : FR_PUSH;
        end
      end
      FR_DIV: begin
        if (step_q == StepW'(KC_DIV_STEPS - 1)) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!job_full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    full_o     = 1'b1;
    job_push_o = 1'b0;
    unique case (state_q)
      FR_IDLE: full_o     = init_busy_i;
      FR_DIV:  full_o     = 1'b1;
      FR_PUSH: job_push_o = !job_full_i;
      default: full_o     = 1'b1;
    endcase
  end

  assign job_data_o = {cmd_q, two_q, lo_q, hi_q, idx_q, rem_q[BiW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == FR_DIV) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      two_q <= two_in;
      lo_q  <= kmer_low_i;
      hi_q  <= hi_in;
      idx_q <= entry_index_i;
      sum_q <= kmer_low_i + hi_in;
      rem_q <= '0;
    end else if (state_q == FR_DIV) begin
      sum_q <= sum_n;
      rem_q <= rem_n;
    end
  end

endmodule

### hdl/kcht_back.sv
// ----------------------------------------------------------------------------
// kcht_back
// Executes jobs: chain walk, insert, read-out and clear over table memories.
// ----------------------------------------------------------------------------
module kcht_back import kcht_pkg::*; #(
  parameter int BUCKETS    = KC_BUCKETS_DEF,
  parameter int NODES      = KC_NODES_DEF,
  parameter int COUNT_BITS = KC_COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [KC_NLIMIT_W-1:0]   node_limit_i,
  output logic                     init_busy_o,
  input  logic                     job_valid_i,
  input  logic [2+1+2*KC_WORD_W+KC_IDX_W+$clog2(BUCKETS)-1:0] job_data_i,
  output logic                     job_pop_o,
  output logic                     res_valid_o,
  input  logic                     res_pop_i,
  output kcht_status_e             status_o,
  output logic [KC_WORD_W-1:0]     result_kmer_low_o,
  output logic [KC_WORD_W-1:0]     result_kmer_high_o,
  output logic [KC_RCOUNT_W-1:0]   result_count_o,
  output logic [KC_IDX_W-1:0]      entries_used_o
);

  localparam int BiW     = $clog2(BUCKETS);
  localparam int NodeW   = $clog2(NODES);
  localparam int NfW     = NodeW + 1;
  localparam int NodeMax = NODES - 1;

  localparam logic [NodeW-1:0] NullId = NodeW'(KC_NODE_ID_NULL);

  kcht_bk_state_e state_q, state_d;

  // job fields
  logic [1:0]           j_cmd;
  logic                 j_two;
  logic [KC_WORD_W-1:0] j_lo, j_hi;
  logic [KC_IDX_W-1:0]  j_idx;
  logic [BiW-1:0]       j_bucket;
  assign {j_cmd, j_two, j_lo, j_hi, j_idx, j_bucket} = job_data_i;

  logic                 two_q;
  logic [KC_WORD_W-1:0] lo_q, hi_q;
  logic [BiW-1:0]       bucket_q;
  logic [NodeW-1:0]     cur_q, prev_q, cur;
  logic                 from_head_q;
  logic [NfW-1:0]       nf_q, nf_m1, usable;
  logic                 locked_q;
  logic [BiW-1:0]       clr_cnt_q;
  logic                 clr_cmd_q;

  // memories
  logic [NodeW-1:0]      heads_mem [BUCKETS];
  logic [NodeW-1:0]      link_mem  [NODES];
  logic [KC_WORD_W-1:0]  lo_mem    [NODES];
  logic [KC_WORD_W-1:0]  hi_mem    [NODES];
  logic [COUNT_BITS-1:0] cnt_mem   [NODES];
  logic [NodeW-1:0]      heads_rd_q, link_rd_q;
  logic [KC_WORD_W-1:0]  lo_rd_q, hi_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q, cnt_inc;

  logic                  hd_re, hd_we, nd_re, wd_we, cnt_we, lk_we;
  logic [BiW-1:0]        hd_waddr;
  logic [NodeW-1:0]      hd_wdata, nd_raddr, cnt_waddr, lk_waddr, lk_wdata;
  logic [COUNT_BITS-1:0] cnt_wdata;

  logic                  take, exhausted, in_range, match, sweep_last;
  logic [31:0]           idx_p1;
  logic [NodeW-1:0]      new_id;

  logic                  res_set;
  kcht_status_e          res_status_n, res_status_q;
  logic [KC_WORD_W-1:0]  res_lo_n, res_hi_n, res_lo_q, res_hi_q;
  logic [KC_RCOUNT_W-1:0] res_cnt_n, res_cnt_q;
  logic [KC_IDX_W-1:0]   res_used_n, res_used_q;
  logic                  res_valid_q;

  assign usable = ({20'd0, node_limit_i} > 32'(NodeMax)) ? NfW'(NodeMax)
                                                          : NfW'(node_limit_i);
  assign nf_m1      = nf_q - NfW'(1);
  assign exhausted  = nf_q > usable;
  assign new_id     = nf_q[NodeW-1:0];
  assign idx_p1     = 32'(j_idx) + 32'd1;
  assign in_range   = 32'(j_idx) < 32'(nf_m1);
  assign take       = (state_q == BK_IDLE) && job_valid_i && !res_valid_q;
  assign cur        = from_head_q ? heads_rd_q : link_rd_q;
  assign match      = (lo_rd_q == lo_q) && (!two_q || (hi_rd_q == hi_q));
  assign cnt_inc    = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;
  assign sweep_last = (clr_cnt_q == BiW'(BUCKETS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_SWEEP: if (sweep_last) state_d = BK_IDLE;
      BK_IDLE: begin
        if (take) begin
          case (j_cmd)
            CMD_ADD:   state_d = BK_WALK;
            CMD_READ:  state_d = in_range ? BK_RDOUT : BK_IDLE;
            CMD_CLEAR: state_d = BK_SWEEP;
            default:   state_d = BK_IDLE;
          endcase
        end
      end
      BK_WALK: begin
        if (cur != NullId) begin
          state_d = BK_CMP;
        end else if (locked_q || exhausted) begin
          state_d = BK_IDLE;
        end else begin
          state_d = BK_LINK;
        end
      end
      BK_CMP:   state_d = match ? BK_IDLE : BK_WALK;
      BK_LINK:  state_d = BK_IDLE;
      BK_RDOUT: state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    hd_re        = 1'b0;
    hd_we        = 1'b0;
    hd_waddr     = clr_cnt_q;
    hd_wdata     = NullId;
    nd_re        = 1'b0;
    nd_raddr     = cur;
    wd_we        = 1'b0;
    cnt_we       = 1'b0;
    cnt_waddr    = new_id;
    cnt_wdata    = COUNT_BITS'(1);
    lk_we        = 1'b0;
    lk_waddr     = new_id;
    lk_wdata     = NullId;
    job_pop_o    = 1'b0;
    res_set      = 1'b0;
    res_status_n = ST_RANGE;
    res_lo_n     = '0;
    res_hi_n     = '0;
    res_cnt_n    = '0;
    res_used_n   = KC_IDX_W'(nf_m1);
    init_busy_o  = 1'b0;
    unique case (state_q)
      BK_SWEEP: begin
        hd_we       = 1'b1;
        init_busy_o = !clr_cmd_q;
        if (sweep_last && clr_cmd_q) begin
          res_set      = 1'b1;
          res_status_n = ST_CLEARED;
          res_used_n   = '0;
        end
      end
      BK_IDLE: begin
        job_pop_o = take;
        hd_re     = take;
        if (take) begin
          case (j_cmd)
            CMD_ADD: ;
            CMD_READ: begin
              nd_re    = in_range;
              nd_raddr = idx_p1[NodeW-1:0];
              res_set  = !in_range;
            end
            CMD_CLEAR: ;
            default: res_set = 1'b1;
          endcase
        end
      end
      BK_WALK: begin
        if (cur != NullId) begin
          nd_re = 1'b1;
        end else if (locked_q || exhausted) begin
          res_set      = 1'b1;
          res_status_n = ST_REJECTED;
        end else begin
          wd_we  = 1'b1;
          cnt_we = 1'b1;
          lk_we  = 1'b1;
        end
      end
      BK_CMP: begin
        if (match) begin
          cnt_we       = 1'b1;
          cnt_waddr    = cur_q;
          cnt_wdata    = cnt_inc;
          res_set      = 1'b1;
          res_status_n = ST_COUNTED;
          res_cnt_n    = KC_RCOUNT_W'(cnt_inc);
        end
      end
      BK_LINK: begin
        if (prev_q == NullId) begin
          hd_we    = 1'b1;
          hd_waddr = bucket_q;
          hd_wdata = new_id;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = prev_q;
          lk_wdata = new_id;
        end
        res_set      = 1'b1;
        res_status_n = ST_INSERTED;
        res_cnt_n    = KC_RCOUNT_W'(1);
        res_used_n   = KC_IDX_W'(nf_q);
      end
      BK_RDOUT: begin
        res_set      = 1'b1;
        res_status_n = ST_READ;
        res_lo_n     = lo_rd_q;
        res_hi_n     = hi_rd_q;
        res_cnt_n    = KC_RCOUNT_W'(cnt_rd_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_SWEEP;
      clr_cnt_q   <= '0;
      clr_cmd_q   <= 1'b0;
      nf_q        <= NfW'(1);
      locked_q    <= 1'b0;
      from_head_q <= 1'b0;
      prev_q      <= NullId;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_SWEEP) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (take && (j_cmd == CMD_CLEAR)) begin
        clr_cnt_q <= '0;
        clr_cmd_q <= 1'b1;
        nf_q      <= NfW'(1);
        locked_q  <= 1'b0;
      end
      if (take && (j_cmd == CMD_ADD)) begin
        from_head_q <= 1'b1;
        prev_q      <= NullId;
        if (!locked_q && exhausted) begin
          locked_q <= 1'b1;
        end
      end
      if (state_q == BK_CMP) begin
        from_head_q <= 1'b0;
        prev_q      <= cur_q;
      end
      if (state_q == BK_LINK) begin
        nf_q <= nf_q + 1'b1;
      end
      if (res_set) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      two_q    <= j_two;
      lo_q     <= j_lo;
      hi_q     <= j_hi;
      bucket_q <= j_bucket;
    end
    if (state_q == BK_WALK) begin
      cur_q <= cur;
    end
    if (res_set) begin
      res_status_q <= res_status_n;
      res_lo_q     <= res_lo_n;
      res_hi_q     <= res_hi_n;
      res_cnt_q    <= res_cnt_n;
      res_used_q   <= res_used_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) heads_mem[hd_waddr] <= hd_wdata;
    if (hd_re) heads_rd_q <= heads_mem[j_bucket];
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    if (nd_re) link_rd_q <= link_mem[nd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wd_we) lo_mem[new_id] <= lo_q;
    if (nd_re) lo_rd_q <= lo_mem[nd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wd_we) hi_mem[new_id] <= hi_q;
    if (nd_re) hi_rd_q <= hi_mem[nd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (nd_re) cnt_rd_q <= cnt_mem[nd_raddr];
  end

  assign res_valid_o        = res_valid_q;
  assign status_o           = res_status_q;
  assign result_kmer_low_o  = res_lo_q;
  assign result_kmer_high_o = res_hi_q;
  assign result_count_o     = res_cnt_q;
  assign entries_used_o     = res_used_q;

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_pop_i |-> !res_set)
    else $error("result overwritten while waiting");

  // the pool never hands out a node beyond the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_LINK |-> !exhausted && !locked_q)
    else $error("node allocated from exhausted pool");

  // next free node is never the null link
  assert property (@(posedge clk_i) disable iff (!rst_ni) nf_q != '0)
    else $error("free pointer at null");

  // a completed clear leaves an empty pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_set && res_status_n == ST_CLEARED |=> nf_q == NfW'(1) && !locked_q)
    else $error("clear left pool state behind");

endmodule

### hdl/kmer_count_chained_hash_table_unit.sv
// ----------------------------------------------------------------------------
// kmer_count_chained_hash_table_unit
// K-mer counter on a chained hash table with a fixed node pool.
// ----------------------------------------------------------------------------
// Commands go in as beats on a queue-like port (push/full) and one result
// beat per command comes out (empty/pop). An add hashes the k-mer (sum of
// its words modulo table_size, clamped to 1..BUCKETS) in the front end, 4
// remainder bits a cycle; the back end then walks the bucket's chain,
// reading and comparing one node at a time, and links a new node for an
// insert. Front and back overlap through a 2-deep job queue, so the front
// end can hash the next add while the back end walks a chain; a stream of
// adds is bounded by the back end's chain walk when chains are long. After
// reset, and on every clear command, the bucket heads are swept to null one
// per cycle (BUCKETS heads, 8192 by default); no beat is taken during the
// reset sweep. Configuration writes must only be made while the block is idle.
// ----------------------------------------------------------------------------
module kmer_count_chained_hash_table_unit import kcht_pkg::*; #(
  parameter int BUCKETS    = KC_BUCKETS_DEF,
  parameter int NODES      = KC_NODES_DEF,
  parameter int COUNT_BITS = KC_COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [KC_CFGIDX_W-1:0] cfg_idx_i,
  input  logic [KC_CFG_W-1:0]    cfg_wdata_i,
  // command side
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             command_i,
  input  logic [KC_WORD_W-1:0]   kmer_low_i,
  input  logic [KC_WORD_W-1:0]   kmer_high_i,
  input  logic [KC_IDX_W-1:0]    entry_index_i,
  // result side
  output logic                   empty,
  input  logic                   pop,
  output logic [2:0]             status_o,
  output logic [KC_WORD_W-1:0]   result_kmer_low_o,
  output logic [KC_WORD_W-1:0]   result_kmer_high_o,
  output logic [KC_RCOUNT_W-1:0] result_count_o,
  output logic [KC_IDX_W-1:0]    entries_used_o
);

  localparam int JobW = 2 + 1 + 2 * KC_WORD_W + KC_IDX_W + $clog2(BUCKETS);

  logic [KC_TSIZE_W-1:0]  table_size_q;
  logic [KC_KWORDS_W-1:0] kmer_words_q;
  logic [KC_NLIMIT_W-1:0] node_limit_q;

  logic            init_busy, f_push, f_full, f_pop, f_empty, res_valid;
  logic [JobW-1:0] f_wdata, f_rdata;
  kcht_status_e    status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= KC_TSIZE_W'(8191);
      kmer_words_q <= KC_KWORDS_W'(1);
      node_limit_q <= KC_NLIMIT_W'(4095);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TABLE_SIZE: table_size_q <= cfg_wdata_i;
        REG_KMER_WORDS: kmer_words_q <= cfg_wdata_i[KC_KWORDS_W-1:0];
        REG_NODE_LIMIT: node_limit_q <= cfg_wdata_i[KC_NLIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: beat intake and bucket hash
  kcht_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .table_size_i  (table_size_q),
    .kmer_words_i  (kmer_words_q),
    .init_busy_i   (init_busy),
    .push_i        (push),
    .full_o        (full),
    .command_i     (command_i),
    .kmer_low_i    (kmer_low_i),
    .kmer_high_i   (kmer_high_i),
    .entry_index_i (entry_index_i),
    .job_push_o    (f_push),
    .job_data_o    (f_wdata),
    .job_full_i    (f_full)
  );

  // decouples hashing from the table walk
  kcht_fifo #(
    .WIDTH (JobW),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_wdata),
    .full_o  (f_full),
    .pop_i   (f_pop),
    .rdata_o (f_rdata),
    .empty_o (f_empty)
  );

  // back end: table memories and result register
  kcht_back #(
    .BUCKETS    (BUCKETS),
    .NODES      (NODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .node_limit_i       (node_limit_q),
    .init_busy_o        (init_busy),
    .job_valid_i        (!f_empty),
    .job_data_i         (f_rdata),
    .job_pop_o          (f_pop),
    .res_valid_o        (res_valid),
    .res_pop_i          (pop),
    .status_o           (status),
    .result_kmer_low_o  (result_kmer_low_o),
    .result_kmer_high_o (result_kmer_high_o),
    .result_count_o     (result_count_o),
    .entries_used_o     (entries_used_o)
  );

  assign empty    = !res_valid;
  assign status_o = status;

endmodule

### bench/kmer_count_chained_hash_table_unit_tb.sv
// ----------------------------------------------------------------------------
// kmer_count_chained_hash_table_unit_tb
// Self-checking bench for the chained hash table k-mer counter.
// ----------------------------------------------------------------------------
// A directed table of commands runs first: empty reads, the unknown command,
// the first insert and count, extreme words, bucket collisions, reads at the
// edge of the used range and a clear. The random phases that follow step
// through register settings, from one bucket to beyond BUCKETS, one and two
// word keys, and pool sizes from empty to full. Keys are mostly drawn from a
// pool of recent keys, so chains form, counts climb and the pool runs dry and
// locks. Each result beat is checked against a typed-in expectation or a
// behavioural model of the table with its own copy of state and registers.
// ----------------------------------------------------------------------------
module kmer_count_chained_hash_table_unit_tb;
  import kcht_pkg::*;

  localparam int BKTS  = KC_BUCKETS_DEF;
  localparam int NPOOL = KC_NODES_DEF;
  // clear sweep touches every bucket head, one a cycle
  localparam int SWEEP_WAIT = BKTS + 100;
  // command code with no meaning
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]          cmd;
    logic [KC_WORD_W-1:0] lo;
    logic [KC_WORD_W-1:0] hi;
    logic [KC_IDX_W-1:0]  idx;
  } cmd_beat_t;

  typedef struct {
    kcht_status_e          status;
    logic [KC_WORD_W-1:0]   lo;
    logic [KC_WORD_W-1:0]   hi;
    logic [KC_RCOUNT_W-1:0] cnt;
    logic [KC_IDX_W-1:0]    used;
  } result_beat_t;

  // directed row: the expectation is typed in only where fixed_exp is set
  typedef struct {
    logic [1:0]           cmd;
    logic [KC_WORD_W-1:0] lo;
    logic [KC_WORD_W-1:0] hi;
    logic [KC_IDX_W-1:0]  idx;
    bit                   fixed_exp;
    kcht_status_e         status;
    logic [31:0]          cnt;
    logic [KC_IDX_W-1:0]  used;
  } dir_row_t;

  typedef struct {
    logic [KC_WORD_W-1:0] lo;
    logic [KC_WORD_W-1:0] hi;
  } key_t;

  typedef struct {
    int unsigned ts;
    int unsigned kw;
    int unsigned nl;
    int          beats;
    bit          clear_first;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [KC_CFGIDX_W-1:0] cfg_idx_i;
  logic [KC_CFG_W-1:0]    cfg_wdata_i;
  logic push, full, empty, pop;
  logic [1:0]             command_i;
  logic [KC_WORD_W-1:0]   kmer_low_i, kmer_high_i;
  logic [KC_IDX_W-1:0]    entry_index_i;
  logic [2:0]             status_o;
  logic [KC_WORD_W-1:0]   result_kmer_low_o, result_kmer_high_o;
  logic [KC_RCOUNT_W-1:0] result_count_o;
  logic [KC_IDX_W-1:0]    entries_used_o;

  kmer_count_chained_hash_table_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .command_i, .kmer_low_i, .kmer_high_i, .entry_index_i,
    .empty, .pop, .status_o, .result_kmer_low_o, .result_kmer_high_o,
    .result_count_o, .entries_used_o
  );

  always #5 clk_i = ~clk_i;

  // ---- table model: its own state and register copies ----
  logic [KC_IDX_W-1:0]    head_of [BKTS];
  logic [KC_IDX_W-1:0]    link_of [NPOOL];
  logic [KC_WORD_W-1:0]   low_of  [NPOOL];
  logic [KC_WORD_W-1:0]   high_of [NPOOL];
  logic [KC_RCOUNT_W-1:0] tally_of[NPOOL];
  int unsigned next_free;
  bit          pool_locked;
  logic [KC_TSIZE_W-1:0]  m_table_size;
  logic [KC_KWORDS_W-1:0] m_kmer_words;
  logic [KC_NLIMIT_W-1:0] m_node_limit;

  result_beat_t pending_results[$];
  key_t         key_pool[$];
  int           fault_count = 0;
  int           hold_len = 0;

  task automatic count_kmer_beat(input cmd_beat_t b, output result_beat_t r);
    logic [KC_WORD_W-1:0] lo, hi, key_sum;
    int unsigned ub, bkt, cur, prev, steps;
    bit two, found;
    r = '{ST_RANGE, '0, '0, '0, '0};
    found = 1'b0;
    case (b.cmd)
      CMD_ADD: begin
        two = m_kmer_words >= 2;
        lo = b.lo;
        hi = two ? b.hi : '0;
        ub = (m_table_size == 0) ? 1 : (m_table_size > BKTS) ? BKTS : m_table_size;
        key_sum = lo + hi;
        bkt = 32'(key_sum % 64'(ub));
        // lock test comes first, even for a key already present
        if (!pool_locked && next_free > m_node_limit) pool_locked = 1'b1;
        cur = head_of[bkt];
        prev = KC_NODE_ID_NULL;
        steps = 0;
        while (cur != KC_NODE_ID_NULL && steps < NPOOL && !found) begin
          if (low_of[cur] == lo && (!two || high_of[cur] == hi)) found = 1'b1;
          else begin
            prev = cur;
            cur = link_of[cur];
            steps++;
          end
        end
        if (found) begin
          if (tally_of[cur] != '1) tally_of[cur]++;
          r.status = ST_COUNTED;
          r.cnt = tally_of[cur];
        end else if (pool_locked || next_free > m_node_limit) begin
          r.status = ST_REJECTED;
        end else begin
          cur = next_free % NPOOL;
          low_of[cur] = lo;
          high_of[cur] = hi;
          tally_of[cur] = KC_RCOUNT_W'(1);
          link_of[cur] = KC_IDX_W'(KC_NODE_ID_NULL);
          if (prev == KC_NODE_ID_NULL) head_of[bkt] = KC_IDX_W'(cur);
          else link_of[prev] = KC_IDX_W'(cur);
          next_free++;
          r.status = ST_INSERTED;
          r.cnt = KC_RCOUNT_W'(1);
        end
      end
      CMD_READ: begin
        if (b.idx < next_free - 1) begin
          cur = (b.idx + 1) % NPOOL;
          r = '{ST_READ, low_of[cur], high_of[cur], tally_of[cur], '0};
        end
      end
      CMD_CLEAR: begin
        foreach (head_of[i]) head_of[i] = KC_IDX_W'(KC_NODE_ID_NULL);
        next_free = 1;
        pool_locked = 1'b0;
        r.status = ST_CLEARED;
      end
      default: ;  // unknown command: out of range, nothing else changes
    endcase
    r.used = KC_IDX_W'(next_free - 1);
  endtask

  // ---- command side ----
  task automatic send_beat(input cmd_beat_t b, input bit fixed_exp,
                           input result_beat_t fixed_res);
    int gap;
    result_beat_t r;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk_i) push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    command_i <= b.cmd;
    kmer_low_i <= b.lo;
    kmer_high_i <= b.hi;
    entry_index_i <= b.idx;
    do @(posedge clk_i); while (full);
    count_kmer_beat(b, r);
    pending_results.push_back(fixed_exp ? fixed_res : r);
  endtask

  task automatic write_reg(input kcht_reg_e idx, input int unsigned val);
    @(negedge clk_i);
    push <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= KC_CFG_W'(val);
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (idx)
      REG_TABLE_SIZE: m_table_size = KC_TSIZE_W'(val);
      REG_KMER_WORDS: m_kmer_words = KC_KWORDS_W'(val);
      default:        m_node_limit = KC_NLIMIT_W'(val);
    endcase
  endtask

  // stop offering the last beat before waiting, so it is not taken twice
  task automatic wait_drained();
    @(negedge clk_i) push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic cmd_beat_t random_beat(input bit allow_clear);
    cmd_beat_t b;
    key_t k;
    int sel;
    sel = $urandom_range(0, 999);
    b.idx = KC_IDX_W'($urandom);
    b.lo = {$urandom, $urandom};
    b.hi = {$urandom, $urandom};
    if (sel < 700) begin
      b.cmd = CMD_ADD;
      if (key_pool.size() != 0 && $urandom_range(0, 9) < 6) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        b.lo = k.lo;
        // a stale high word only matters for two-word keys
        b.hi = ($urandom_range(0, 9) == 0) ? ~k.hi : k.hi;
      end else if ($urandom_range(0, 19) == 0) begin
        b.lo = $urandom_range(0, 1) ? '1 : '0;
        b.hi = $urandom_range(0, 1) ? '1 : '0;
      end
      k = '{b.lo, b.hi};
      key_pool.push_back(k);
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end else if (sel < 950) begin
      b.cmd = CMD_READ;
      if ($urandom_range(0, 9) < 7) b.idx = KC_IDX_W'($urandom_range(0, next_free + 1));
    end else if (sel < 980 || !allow_clear) begin
      b.cmd = CMD_UNKNOWN;
    end else begin
      b.cmd = CMD_CLEAR;
    end
    return b;
  endfunction

  dir_row_t dir_rows[14];
  phase_t   phases[6];

  initial begin
    result_beat_t none;
    cmd_beat_t b;
    int clears;
    none = '{ST_RANGE, '0, '0, '0, '0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TABLE_SIZE;
    cfg_wdata_i = '0;
    push = 1'b0;
    command_i = CMD_ADD;
    kmer_low_i = '0;
    kmer_high_i = '0;
    entry_index_i = '0;
    m_table_size = KC_TSIZE_W'(8191);
    m_kmer_words = KC_KWORDS_W'(1);
    m_node_limit = KC_NLIMIT_W'(4095);
    next_free = 1;
    pool_locked = 1'b0;
    foreach (head_of[i]) head_of[i] = KC_IDX_W'(KC_NODE_ID_NULL);

    // reset settings: 8191 buckets, one word, 4095 nodes
    dir_rows = '{
      '{CMD_READ,    '0, '0, 12'd0,    1'b1, ST_RANGE,    0, 12'd0},
      '{CMD_UNKNOWN, '0, '0, 12'd0,    1'b1, ST_RANGE,    0, 12'd0},
      '{CMD_ADD,     '0, '0, 12'd0,    1'b1, ST_INSERTED, 1, 12'd1},
      '{CMD_ADD,     '0, '1, 12'd0,    1'b1, ST_COUNTED,  2, 12'd1},
      '{CMD_ADD,     '1, '1, 12'd0,    1'b1, ST_INSERTED, 1, 12'd2},
      '{CMD_ADD,     64'd8191, '0, '0, 1'b0, ST_RANGE,    0, 12'd0},  // same bucket as 0
      '{CMD_ADD,     64'd8191, '0, '0, 1'b0, ST_RANGE,    0, 12'd0},
      '{CMD_READ,    '0, '0, 12'd0,    1'b0, ST_RANGE,    0, 12'd0},
      '{CMD_READ,    '0, '0, 12'd2,    1'b0, ST_RANGE,    0, 12'd0},
      '{CMD_READ,    '0, '0, 12'd3,    1'b1, ST_RANGE,    0, 12'd3},
      '{CMD_READ,    '0, '0, 12'hFFF,  1'b1, ST_RANGE,    0, 12'd3},
      '{CMD_ADD,     '1, '0, 12'd0,    1'b0, ST_RANGE,    0, 12'd0},
      '{CMD_CLEAR,   '0, '0, 12'd0,    1'b1, ST_CLEARED,  0, 12'd0},
      '{CMD_ADD,     64'd5, '0, '0,    1'b1, ST_INSERTED, 1, 12'd1}
    };
    // table size, key words, node limit, beats, clear on entry
    phases = '{
      '{1,     2, 8,    150, 1'b1},
      '{0,     3, 0,    80,  1'b1},
      '{16383, 0, 4095, 400, 1'b0},  // starts locked: a larger pool must not unlock
      '{8192,  2, 4095, 300, 1'b1},
      '{13,    1, 60,   250, 1'b1},
      '{2,     2, 25,   220, 1'b1}
    };

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      b = '{dir_rows[i].cmd, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].idx};
      send_beat(b, dir_rows[i].fixed_exp,
                '{dir_rows[i].status, '0, '0, dir_rows[i].cnt, dir_rows[i].used});
    end

    foreach (phases[p]) begin
      wait_drained();
      @(negedge clk_i) push <= 1'b0;
      repeat (SWEEP_WAIT) @(posedge clk_i);
      write_reg(REG_TABLE_SIZE, phases[p].ts);
      write_reg(REG_KMER_WORDS, phases[p].kw);
      write_reg(REG_NODE_LIMIT, phases[p].nl);
      key_pool.delete();
      if (phases[p].clear_first) send_beat('{CMD_CLEAR, '0, '0, '0}, 1'b0, none);
      clears = 0;
      for (int n = 0; n < phases[p].beats; n++) begin
        if (p == 3 && n == 100) hold_len = 300;  // let the block back up
        if (p == 3 && n == 200) begin
          wait_drained();
        end
        b = random_beat(clears < 2);
        if (b.cmd == CMD_CLEAR) clears++;
        send_beat(b, 1'b0, none);
      end
    end

    @(negedge clk_i) push <= 1'b0;
    wait_drained();
    repeat (SWEEP_WAIT) @(posedge clk_i);
    if (fault_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---- result side ----
  initial begin
    int n;
    result_beat_t e;
    pop = 1'b0;
    forever begin
      n = $urandom_range(0, 9);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end
      if (n > 0) begin
        @(negedge clk_i) pop <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) pop <= 1'b1;
      do @(posedge clk_i); while (empty || !rst_ni);
      if (pending_results.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result beat, status %0d", $time, status_o);
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status || result_kmer_low_o !== e.lo ||
            result_kmer_high_o !== e.hi || result_count_o !== e.cnt ||
            entries_used_o !== e.used) begin
          fault_count++;
          $display("%0t: expected st %0d lo %h hi %h cnt %0d used %0d", $time,
                   e.status, e.lo, e.hi, e.cnt, e.used);
          $display("%0t: actual   st %0d lo %h hi %h cnt %0d used %0d", $time,
                   status_o, result_kmer_low_o, result_kmer_high_o,
                   result_count_o, entries_used_o);
        end
      end
    end
  end

  // watchdog
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### kmer_count_chained_hash_table_unit.f
hdl/kcht_pkg.sv
hdl/kcht_fifo.sv
hdl/kcht_front.sv
hdl/kcht_back.sv
hdl/kmer_count_chained_hash_table_unit.sv
bench/kmer_count_chained_hash_table_unit_tb.sv
